FILE: hw/rtl/qcsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcsf_pkg
// Shared types and constants of the quad corner shear filter.
// ----------------------------------------------------------------------------
package qcsf_pkg;

  localparam int EDGE_W  = 33;
  localparam int PROD_W  = 66;
  localparam int SUM_W   = 68;
  localparam int DOTA_W  = 67;
  localparam int SINE_W  = 17;
  localparam int SSQ_W   = 34;
  localparam int DSQ_W   = 134;
  localparam int NN_W    = 136;
  localparam int RHS_W   = 170;
  localparam int IDX_W   = 14;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BYPASS  = 3'd1;
  localparam logic [2:0] ST_FEW     = 3'd2;
  localparam logic [2:0] ST_BAD_IDX = 3'd3;
  localparam logic [2:0] ST_SHORT   = 3'd4;
  localparam logic [2:0] ST_SHEARED = 3'd5;

  localparam logic [1:0] REG_FILTER_ENABLE = 2'd0;
  localparam logic [1:0] REG_SHEAR_SINE    = 2'd1;
  localparam logic [1:0] REG_MIN_EDGE_SQ   = 2'd2;
  localparam logic [1:0] REG_POINT_COUNT   = 2'd3;

  typedef struct packed {
    logic short_edge;
    logic sheared;
  } lane_res_t;

  typedef struct packed {
    logic                    valid;
    logic [2:0]              pre;
    logic [IDX_W-1:0]        a;
    logic [IDX_W-1:0]        b;
    logic [IDX_W-1:0]        c;
    logic [IDX_W-1:0]        d;
  } ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/qcsf_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcsf_store
// One copy of the point store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module qcsf_store #(
  parameter int DEPTH = 4096,
  parameter int DW    = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/qcsf_wmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcsf_wmul
// Two-stage unsigned wide multiplier: 32x32 partial products, then a sum.
// ----------------------------------------------------------------------------
module qcsf_wmul #(
  parameter int AW = 68,
  parameter int BW = 68
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output      logic [AW+BW-1:0] p
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int PW = AW + BW;

  logic [NA*32-1:0] a_pad;
  logic [NB*32-1:0] b_pad;
  logic [63:0]      pp [NA][NB];
  logic [PW-1:0]    sum;

  assign a_pad = (NA*32)'(a);
  assign b_pad = (NB*32)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= 64'(a_pad[i*32 +: 32]) * 64'(b_pad[j*32 +: 32]);
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (PW'(pp[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/qcsf_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcsf_lane
// Corner test: edge lengths against the minimum and the shear angle test,
// dot^2 * 2^32 <= s^2 * |e1|^2 * |e2|^2. Nine register stages.
// ----------------------------------------------------------------------------
module qcsf_lane
  import qcsf_pkg::*;
#(
  parameter int CW = 32
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [3*CW-1:0] p_prev,
  input  wire logic [3*CW-1:0] p_cur,
  input  wire logic [3*CW-1:0] p_next,
  input  wire logic [31:0]     min_edge_sq,
  input  wire logic [SSQ_W-1:0] sine_sq,
  output      lane_res_t       res
);

  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [PROD_W-1:0] q11 [3];
  logic signed [PROD_W-1:0] q22 [3];
  logic signed [PROD_W-1:0] q12 [3];
  logic [SUM_W-1:0]         n1;
  logic [SUM_W-1:0]         n2;
  logic signed [SUM_W-1:0]  dot;
  logic [SUM_W-1:0]         n1_r;
  logic [SUM_W-1:0]         n2_r;
  logic [DOTA_W-1:0]        dot_abs;
  logic [DSQ_W-1:0]         dot_sq;
  logic [NN_W-1:0]          nn;
  logic [RHS_W-1:0]         rhs;
  logic [DSQ_W-1:0]         dsq_d1;
  logic [DSQ_W-1:0]         dsq_d2;
  logic [4:0]               short_d;
  logic                     short_now;
  logic [RHS_W-1:0]         lhs;

  function automatic logic signed [EDGE_W-1:0] coord(input logic [3*CW-1:0] p,
                                                     input int k);
    logic [CW-1:0] raw;
    raw = p[k*CW +: CW];
    return EDGE_W'(signed'(raw));
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= coord(p_prev, k) - coord(p_cur, k);
        e2[k] <= coord(p_next, k) - coord(p_cur, k);
      end
      for (int k = 0; k < 3; k++) begin
        q11[k] <= PROD_W'(e1[k]) * PROD_W'(e1[k]);
        q22[k] <= PROD_W'(e2[k]) * PROD_W'(e2[k]);
        q12[k] <= PROD_W'(e1[k]) * PROD_W'(e2[k]);
      end
      n1  <= SUM_W'(unsigned'(q11[0])) + SUM_W'(unsigned'(q11[1]))
             + SUM_W'(unsigned'(q11[2]));
      n2  <= SUM_W'(unsigned'(q22[0])) + SUM_W'(unsigned'(q22[1]))
             + SUM_W'(unsigned'(q22[2]));
      dot <= SUM_W'(q12[0]) + SUM_W'(q12[1]) + SUM_W'(q12[2]);
      n1_r    <= n1;
      n2_r    <= n2;
      dot_abs <= dot[SUM_W-1] ? DOTA_W'(-dot) : DOTA_W'(dot);
      short_d <= {short_d[3:0], short_now};
      dsq_d1  <= dot_sq;
      dsq_d2  <= dsq_d1;
      res.short_edge <= short_d[4];
      res.sheared    <= lhs > rhs;
    end
  end

  assign short_now = (n1 <= SUM_W'(min_edge_sq)) || (n2 <= SUM_W'(min_edge_sq));
  assign lhs       = RHS_W'(dsq_d2) << 32;

  qcsf_wmul #(.AW(DOTA_W), .BW(DOTA_W)) u_dsq (
    .clk (clk), .en (en), .a (dot_abs), .b (dot_abs), .p (dot_sq)
  );

  qcsf_wmul #(.AW(SUM_W), .BW(SUM_W)) u_nn (
    .clk (clk), .en (en), .a (n1_r), .b (n2_r), .p (nn)
  );

  qcsf_wmul #(.AW(NN_W), .BW(SSQ_W)) u_rhs (
    .clk (clk), .en (en), .a (nn), .b (sine_sq), .p (rhs)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/qcsf_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcsf_merge
// Picks the status of the first failing corner, in order a, b, c, d.
// ----------------------------------------------------------------------------
module qcsf_merge
  import qcsf_pkg::*;
(
  input  wire logic      [2:0] pre,
  input  wire lane_res_t       lane [4],
  input  wire logic            filter_enable,
  output      logic      [2:0] status
);

  always_comb begin
    status = pre;
    if (pre == ST_OK) begin
      for (int k = 3; k >= 0; k--) begin
        if (lane[k].short_edge) begin
          status = ST_SHORT;
        end else if (filter_enable && lane[k].sheared) begin
          status = ST_SHEARED;
        end
      end
      if (status == ST_OK && !filter_enable) begin
        status = ST_BYPASS;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/quad_corner_shear_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quad_corner_shear_filter_core
// Point store and quad corner shear filter.
// ----------------------------------------------------------------------------
// One transfer is taken every cycle while in_stall is low, loads and quads
// alike. A quad result passes through a registered store read, nine
// stages of corner arithmetic in four parallel lanes (the wide squares and
// products go through two-stage 32x32 multipliers), then the output
// register. The store is held in four copies so that all four corners are
// read in the same cycle. The pipeline holds only while a result waits at
// the output under stall. Loads produce no result.
module quad_corner_shear_filter_core
  import qcsf_pkg::*;
#(
  parameter int MAX_POINTS  = 4096,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        mode,
  input  wire logic [11:0] point_index,
  input  wire logic [31:0] coord_x,
  input  wire logic [31:0] coord_y,
  input  wire logic [31:0] coord_z,
  input  wire logic [2:0]  corner_count,
  input  wire logic [13:0] corner_a,
  input  wire logic [13:0] corner_b,
  input  wire logic [13:0] corner_c,
  input  wire logic [13:0] corner_d,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        keep,
  output      logic [2:0]  status,
  output      logic [13:0] out_a,
  output      logic [13:0] out_b,
  output      logic [13:0] out_c,
  output      logic [13:0] out_d
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int DW  = 3 * COORD_WIDTH;
  localparam int LAT = 10;

  logic              filter_enable;
  logic [SINE_W-1:0] shear_limit_sine;
  logic [31:0]       min_edge_sq;
  logic [12:0]       point_count;
  logic [SSQ_W-1:0]  sine_sq;

  logic              adv;
  logic              accept;
  logic              load_we;
  logic [16:0]       load_idx;
  logic [16:0]       limit;
  logic [16:0]       cidx [4];
  logic [13:0]       corner [4];
  logic              bad;
  logic [2:0]        pre;
  logic [DW-1:0]     wdata;
  logic [DW-1:0]     rdata [4];
  lane_res_t         lane [4];
  ctl_t              ctl [LAT];
  ctl_t              ctl_in;
  logic [2:0]        status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable    <= 1'b1;
      shear_limit_sine <= SINE_W'(32768);
      min_edge_sq      <= '0;
      point_count      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FILTER_ENABLE: filter_enable    <= cfg_data[0];
        REG_SHEAR_SINE:    shear_limit_sine <= cfg_data[SINE_W-1:0];
        REG_MIN_EDGE_SQ:   min_edge_sq      <= cfg_data;
        REG_POINT_COUNT:   point_count      <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sine_sq <= SSQ_W'(shear_limit_sine) * SSQ_W'(shear_limit_sine);
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  assign load_idx = 17'(point_index);
  assign load_we  = accept && !mode && (load_idx < 17'(MAX_POINTS));
  assign wdata    = {coord_z[COORD_WIDTH-1:0], coord_y[COORD_WIDTH-1:0],
                     coord_x[COORD_WIDTH-1:0]};
  assign limit    = (17'(point_count) < 17'(MAX_POINTS)) ? 17'(point_count)
                                                         : 17'(MAX_POINTS);

  assign corner[0] = corner_a;
  assign corner[1] = corner_b;
  assign corner[2] = corner_c;
  assign corner[3] = corner_d;

  always_comb begin
    bad = 1'b0;
    for (int k = 0; k < 4; k++) begin
      cidx[k] = 17'(corner[k]);
      if (corner[k][13] || cidx[k] >= limit) begin
        bad = 1'b1;
      end
    end
    if (corner_count[2] == 1'b0) begin
      pre = ST_FEW;
    end else if (bad) begin
      pre = ST_BAD_IDX;
    end else begin
      pre = ST_OK;
    end
  end

  assign ctl_in = '{valid: accept && mode, pre: pre, a: corner_a, b: corner_b,
                    c: corner_c, d: corner_d};

  for (genvar k = 0; k < 4; k++) begin : g_store
    qcsf_store #(.DEPTH(MAX_POINTS), .DW(DW)) u_store (
      .clk   (clk),
      .we    (load_we),
      .waddr (load_idx[AW-1:0]),
      .wdata (wdata),
      .re    (adv),
      .raddr (cidx[k][AW-1:0]),
      .rdata (rdata[k])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    qcsf_lane #(.CW(COORD_WIDTH)) u_lane (
      .clk         (clk),
      .en          (adv),
      .p_prev      (rdata[(k + 3) % 4]),
      .p_cur       (rdata[k]),
      .p_next      (rdata[(k + 1) % 4]),
      .min_edge_sq (min_edge_sq),
      .sine_sq     (sine_sq),
      .res         (lane[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        ctl[i].valid <= 1'b0;
      end
    end else if (adv) begin
      ctl[0] <= ctl_in;
      for (int i = 1; i < LAT; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  qcsf_merge u_merge (
    .pre           (ctl[LAT-1].pre),
    .lane          (lane),
    .filter_enable (filter_enable),
    .status        (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl[LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status <= status_next;
      keep   <= (status_next == ST_OK) || (status_next == ST_BYPASS);
      out_a  <= ctl[LAT-1].a;
      out_b  <= ctl[LAT-1].b;
      out_c  <= ctl[LAT-1].c;
      out_d  <= ctl[LAT-1].d;
    end
  end

endmodule
`default_nettype wire
